[sv/adts_frame_splitter_top_defines.svh]
// ----------------------------------------------------------------------------
// ADTS frame splitter assertion macros
// Shared property wrappers for the checker of the frame splitter.
// ----------------------------------------------------------------------------
`ifndef ADTS_FRAME_SPLITTER_TOP_DEFINES_SVH
`define ADTS_FRAME_SPLITTER_TOP_DEFINES_SVH

// Clocked property that is ignored while reset is held.
`define AFS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is checked in every cycle, reset included.
`define AFS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/afs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADTS frame splitter package
// Shared constants and types for the frame splitter modules.
// ----------------------------------------------------------------------------
package afs_pkg;

    // Default header length in bytes (no CRC).
    localparam int HEADER_LEN_DEF = 7;

    // Sync word: first byte all ones, upper nibble of the second byte all ones.
    localparam logic [7:0] SYNC_BYTE   = 8'hFF;
    localparam logic [3:0] SYNC_NIBBLE = 4'hF;

    // One result: a frame byte with the tags of its frame.
    typedef struct packed {
        logic [7:0]  frame_byte;
        logic        frame_first;
        logic        frame_end;
        logic [1:0]  audio_profile;
        logic [3:0]  rate_index;
        logic [12:0] frame_bytes;
        logic [15:0] frame_index;
    } t_item;

    // Push request from the parser to the output queue.
    typedef struct packed {
        logic single;  // one body byte
        logic burst;   // the whole header
    } t_push_ctl;

endpackage

[sv/afs_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADTS frame splitter channels
// Valid/ready interfaces for the byte input and the tagged result output.
// ----------------------------------------------------------------------------

// Raw stream bytes.
interface afs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

// Frame bytes with their tags.
interface afs_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  frame_byte;
    logic        frame_first;
    logic        frame_end;
    logic [1:0]  audio_profile;
    logic [3:0]  rate_index;
    logic [12:0] frame_bytes;
    logic [15:0] frame_index;

    modport source (output valid, output frame_byte, output frame_first,
                    output frame_end, output audio_profile, output rate_index,
                    output frame_bytes, output frame_index, input ready);
    modport sink   (input valid, input frame_byte, input frame_first,
                    input frame_end, input audio_profile, input rate_index,
                    input frame_bytes, input frame_index, output ready);
endinterface

[sv/afs_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADTS frame splitter queue cell
// One slot of the output shift queue: loads a new result or takes its
// neighbor's result when the head is consumed.
// ----------------------------------------------------------------------------
module afs_cell
    import afs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_shift,
    input  t_item i_from_next,
    input  logic  i_load,
    input  t_item i_load_item,
    output t_item o_item
);

    t_item r_item;
    t_item n_item;

    // A new result wins over the shift from the neighbor.
    always_comb begin
        n_item = r_item;
        if (i_load) begin
            n_item = i_load_item;
        end else if (i_shift) begin
            n_item = i_from_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    assign o_item = r_item;

endmodule

[sv/afs_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADTS frame splitter output queue
// A row of cells moving results to the head; takes one body byte or a whole
// header per cycle and hands out one result per cycle while i_ready is high.
// ----------------------------------------------------------------------------
module afs_queue
    import afs_pkg::*;
#(
    parameter int HEADER_LEN = HEADER_LEN_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_push_ctl                   i_push,
    input  t_item [HEADER_LEN-1:0]      i_items,
    output logic                        o_space,
    output logic                        o_valid,
    input  logic                        i_ready,
    output t_item                       o_head
);

    localparam int DEPTH = 2 * HEADER_LEN;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int OFFW  = $clog2(HEADER_LEN);

    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic [CW-1:0] base;
    logic [CW-1:0] push_n;
    logic          pop;

    t_item              cell_q    [DEPTH];
    t_item              cell_next [DEPTH];
    t_item              load_item [DEPTH];
    logic  [DEPTH-1:0]  load;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_cnt != '0);
    assign o_space = (r_cnt <= CW'(DEPTH - HEADER_LEN));
    assign o_head  = cell_q[0];

    // Number of results pushed in this cycle.
    always_comb begin
        push_n = '0;
        if (i_push.burst) begin
            push_n = CW'(HEADER_LEN);
        end else if (i_push.single) begin
            push_n = CW'(1);
        end
    end

    assign base  = r_cnt - CW'(pop);
    assign n_cnt = base + push_n;

    // Each cell loads the pushed result whose offset from the fill point it holds.
    always_comb begin
        logic [CW-1:0]   rel;
        logic [OFFW-1:0] idx;
        for (int i = 0; i < DEPTH; i++) begin
            rel = CW'(i) - base;
            idx = (rel < CW'(HEADER_LEN)) ? rel[OFFW-1:0] : '0;
            load[i]      = (CW'(i) >= base) && (rel < push_n);
            load_item[i] = i_items[idx];
        end
    end

    // Neighbor links; the last cell sees its own contents.
    always_comb begin
        for (int i = 0; i < DEPTH - 1; i++) begin
            cell_next[i] = cell_q[i+1];
        end
        cell_next[DEPTH-1] = cell_q[DEPTH-1];
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        afs_cell u_cell (
            .i_clk       (i_clk),
            .i_shift     (pop),
            .i_from_next (cell_next[g]),
            .i_load      (load[g]),
            .i_load_item (load_item[g]),
            .o_item      (cell_q[g])
        );
    end

    // Fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

[sv/afs_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADTS frame splitter parser
// Keeps the sliding header window, finds the sync word, latches the frame
// tags and counts the frame bytes.
// ----------------------------------------------------------------------------
module afs_ctrl
    import afs_pkg::*;
#(
    parameter int HEADER_LEN = HEADER_LEN_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic [7:0]             i_byte,
    output t_push_ctl              o_push,
    output t_item [HEADER_LEN-1:0] o_items
);

    localparam int FW = $clog2(HEADER_LEN + 1);

    logic [7:0]    r_win [HEADER_LEN];
    logic [7:0]    n_win [HEADER_LEN];
    logic [FW-1:0] r_fill;
    logic [FW-1:0] n_fill;
    logic          r_inside;
    logic          n_inside;
    logic [12:0]   r_left;
    logic [12:0]   n_left;
    logic [1:0]    r_prof;
    logic [1:0]    n_prof;
    logic [3:0]    r_rate;
    logic [3:0]    n_rate;
    logic [12:0]   r_len;
    logic [12:0]   n_len;
    logic [15:0]   r_count;
    logic [15:0]   n_count;

    logic          full;
    logic          body_last;
    logic          sync_hit;
    logic [12:0]   hdr_len;
    logic [1:0]    hdr_prof;
    logic [3:0]    hdr_rate;

    // Window after taking the byte: shift when full, append otherwise.
    assign full = (r_fill >= FW'(HEADER_LEN));
    always_comb begin
        for (int i = 0; i < HEADER_LEN - 1; i++) begin
            if (full) begin
                n_win[i] = r_win[i+1];
            end else begin
                n_win[i] = (FW'(i) == r_fill) ? i_byte : r_win[i];
            end
        end
        n_win[HEADER_LEN-1] = (full || (FW'(HEADER_LEN - 1) == r_fill)) ?
                              i_byte : r_win[HEADER_LEN-1];
    end

    // Header fields of the updated window.
    assign hdr_len  = {n_win[3][1:0], n_win[4], n_win[5][7:5]};
    assign hdr_prof = n_win[2][7:6];
    assign hdr_rate = n_win[2][5:2];
    assign sync_hit = (full || (r_fill == FW'(HEADER_LEN - 1)))
                      && (n_win[0] == SYNC_BYTE)
                      && (n_win[1][7:4] == SYNC_NIBBLE)
                      && (hdr_len >= 13'(HEADER_LEN));

    assign body_last = (r_left <= 13'd1);

    // State update and push requests.
    always_comb begin
        n_fill   = r_fill;
        n_inside = r_inside;
        n_left   = r_left;
        n_prof   = r_prof;
        n_rate   = r_rate;
        n_len    = r_len;
        n_count  = r_count;
        o_push   = '0;
        if (i_accept) begin
            if (r_inside) begin
                o_push.single = 1'b1;
                if (body_last) begin
                    n_count  = r_count + 16'd1;
                    n_inside = 1'b0;
                    n_left   = '0;
                    n_fill   = '0;
                end else begin
                    n_left = r_left - 13'd1;
                end
            end else begin
                n_fill = full ? r_fill : r_fill + FW'(1);
                if (sync_hit) begin
                    o_push.burst = 1'b1;
                    n_prof = hdr_prof;
                    n_rate = hdr_rate;
                    n_len  = hdr_len;
                    n_fill = '0;
                    if (hdr_len == 13'(HEADER_LEN)) begin
                        n_count = r_count + 16'd1;
                    end else begin
                        n_inside = 1'b1;
                        n_left   = hdr_len - 13'(HEADER_LEN);
                    end
                end
            end
        end
    end

    // Results: header bytes from the window, or the body byte in slot zero.
    always_comb begin
        for (int k = 0; k < HEADER_LEN; k++) begin
            o_items[k].frame_byte    = n_win[k];
            o_items[k].frame_first   = (k == 0);
            o_items[k].frame_end     = (k == HEADER_LEN - 1)
                                       && (hdr_len == 13'(HEADER_LEN));
            o_items[k].audio_profile = hdr_prof;
            o_items[k].rate_index    = hdr_rate;
            o_items[k].frame_bytes   = hdr_len;
            o_items[k].frame_index   = r_count;
        end
        if (r_inside) begin
            o_items[0].frame_byte    = i_byte;
            o_items[0].frame_first   = 1'b0;
            o_items[0].frame_end     = body_last;
            o_items[0].audio_profile = r_prof;
            o_items[0].rate_index    = r_rate;
            o_items[0].frame_bytes   = r_len;
        end
    end

    // Window bytes hold no reset value.
    always_ff @(posedge i_clk) begin
        if (i_accept && !r_inside) begin
            for (int i = 0; i < HEADER_LEN; i++) begin
                r_win[i] <= n_win[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_inside <= 1'b0;
            r_left   <= '0;
            r_prof   <= '0;
            r_rate   <= '0;
            r_len    <= '0;
            r_count  <= '0;
        end else begin
            r_fill   <= n_fill;
            r_inside <= n_inside;
            r_left   <= n_left;
            r_prof   <= n_prof;
            r_rate   <= n_rate;
            r_len    <= n_len;
            r_count  <= n_count;
        end
    end

endmodule

[sv/adts_frame_splitter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADTS frame splitter
// Splits an AAC ADTS byte stream into tagged frame bytes.
// ----------------------------------------------------------------------------
//  Channel | Dir | Payload                                   | Transaction
//  i_in    | in  | stream_byte                               | valid & ready
//  o_out   | out | frame_byte, frame_first, frame_end,       | valid & ready
//          |     | audio_profile, rate_index, frame_bytes,   |
//          |     | frame_index                               |
//
//  One input byte is taken per cycle while input ready is high; a result
//  leaves the queue in the cycle after the byte that caused it at the
//  earliest, one result per cycle while output ready is high. The byte that
//  completes a header pushes the whole header into a queue of 2*HEADER_LEN
//  cells; input ready is high while the queue has room for a full header.
//  Synchronous active-low reset empties the queue and restarts the hunt.
//  Stalls on the output hold the head result and back up into the queue.
// ----------------------------------------------------------------------------
module adts_frame_splitter_top
    import afs_pkg::*;
#(
    parameter int HEADER_LEN = HEADER_LEN_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    afs_in_if.sink    i_in,
    afs_out_if.source o_out
);

    t_push_ctl              push;
    t_item [HEADER_LEN-1:0] items;
    t_item                  head;
    logic                   accept;

    assign accept = i_in.valid && i_in.ready;

    // Sync search and frame tracking.
    afs_ctrl #(
        .HEADER_LEN (HEADER_LEN)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in.stream_byte),
        .o_push   (push),
        .o_items  (items)
    );

    // Output queue of cells.
    afs_queue #(
        .HEADER_LEN (HEADER_LEN)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_items (items),
        .o_space (i_in.ready),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_head  (head)
    );

    // Result fields.
    assign o_out.frame_byte    = head.frame_byte;
    assign o_out.frame_first   = head.frame_first;
    assign o_out.frame_end     = head.frame_end;
    assign o_out.audio_profile = head.audio_profile;
    assign o_out.rate_index    = head.rate_index;
    assign o_out.frame_bytes   = head.frame_bytes;
    assign o_out.frame_index   = head.frame_index;

endmodule

[sv/afs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADTS frame splitter checker
// Port-level properties of the frame splitter, bound to the top level.
// ----------------------------------------------------------------------------
`include "adts_frame_splitter_top_defines.svh"

module afs_checker
    import afs_pkg::*;
#(
    parameter int HEADER_LEN = HEADER_LEN_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  i_frame_byte,
    input logic        i_frame_first,
    input logic        i_frame_end,
    input logic [12:0] i_frame_bytes,
    input logic [15:0] i_frame_index
);

    logic out_xact;

    assign out_xact = i_out_valid && i_out_ready;

    // A stalled result keeps its contents.
    `AFS_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_frame_byte) && $stable(i_frame_index), "stalled result changed")

    // The byte after a frame's last byte opens the next frame.
    `AFS_ASSERT(a_next_first, i_clk, i_rst_n, out_xact && i_frame_end |=> !i_out_valid || i_frame_first, "frame end not followed by a frame start")

    // A frame start is a sync byte of a frame at least one header long.
    `AFS_ASSERT(a_first_sync, i_clk, i_rst_n, i_out_valid && i_frame_first |-> i_frame_byte == SYNC_BYTE && i_frame_bytes >= 13'(HEADER_LEN), "frame start without sync")

    // The input is held off only while results are waiting.
    `AFS_ASSERT(a_backpressure, i_clk, i_rst_n, !i_in_ready |-> i_out_valid, "input stalled with empty output")

    // Nothing is offered right after reset.
    `AFS_ASSERT_ALWAYS(a_reset_empty, i_clk, $rose(i_rst_n) |-> !i_out_valid, "result offered after reset")

endmodule

bind adts_frame_splitter_top afs_checker #(
    .HEADER_LEN (HEADER_LEN)
) u_afs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_frame_byte  (o_out.frame_byte),
    .i_frame_first (o_out.frame_first),
    .i_frame_end   (o_out.frame_end),
    .i_frame_bytes (o_out.frame_bytes),
    .i_frame_index (o_out.frame_index)
);

[bench/adts_frame_splitter_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADTS frame splitter checker
// Watches both channels of the frame splitter. It tracks the byte stream with
// its own hunting window and frame state, and queues the tagged frame bytes
// that each accepted stream byte should produce. Each result transaction is
// compared field by field with the oldest queued frame byte.
// ----------------------------------------------------------------------------
module adts_frame_splitter_checker
    import afs_pkg::*;
#(
    parameter int HDR_LEN = HEADER_LEN_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    afs_in_if    in_ch,
    afs_out_if   out_ch,
    output int   o_errors,
    output int   o_pending
);

    // Hunting window and the tags of the frame being passed.
    logic [7:0]  window [HDR_LEN];
    int          fill;
    logic        in_frame;
    logic [12:0] left;
    logic [1:0]  cur_profile;
    logic [3:0]  cur_rate;
    logic [12:0] cur_length;
    logic [15:0] frame_no;

    // Frame bytes still owed by the block, oldest first.
    t_item       owed_bytes [$];
    t_item       seen;
    t_item       want;
    int          errors = 0;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    // Frame byte with the tags of the current frame.
    function automatic t_item tag_byte(input logic [7:0] b, input logic first,
                                       input logic last);
        t_item r;
        r.frame_byte    = b;
        r.frame_first   = first;
        r.frame_end     = last;
        r.audio_profile = cur_profile;
        r.rate_index    = cur_rate;
        r.frame_bytes   = cur_length;
        r.frame_index   = frame_no;
        return r;
    endfunction

    // Closes the current frame and restarts the hunt with an empty window.
    task automatic close_frame();
        frame_no = frame_no + 16'd1;
        in_frame = 1'b0;
        left     = '0;
        fill     = 0;
    endtask

    // Advances the splitter state by one stream byte and queues its results.
    task automatic split_stream_byte(input logic [7:0] b);
        logic [12:0] len;
        int          k;
        if (in_frame) begin
            owed_bytes.push_back(tag_byte(b, 1'b0, left <= 13'd1));
            if (left <= 13'd1) begin
                close_frame();
            end else begin
                left = left - 13'd1;
            end
            return;
        end

        // Slide or fill the window.
        if (fill >= HDR_LEN) begin
            for (k = 0; k < HDR_LEN - 1; k++) begin
                window[k] = window[k + 1];
            end
            window[HDR_LEN - 1] = b;
        end else begin
            window[fill] = b;
            fill++;
        end
        if (fill < HDR_LEN) return;

        // Sync word at the oldest bytes, and a length that covers the header.
        if (window[0] != SYNC_BYTE || window[1][7:4] != SYNC_NIBBLE) return;
        len = {window[3][1:0], window[4], window[5][7:5]};
        if (len < 13'(HDR_LEN)) return;

        cur_profile = window[2][7:6];
        cur_rate    = window[2][5:2];
        cur_length  = len;
        for (k = 0; k < HDR_LEN; k++) begin
            owed_bytes.push_back(tag_byte(window[k], k == 0,
                                          k == HDR_LEN - 1 && len == 13'(HDR_LEN)));
        end
        if (len == 13'(HDR_LEN)) begin
            close_frame();
        end else begin
            in_frame = 1'b1;
            left     = len - 13'(HDR_LEN);
            fill     = 0;
        end
    endtask

    // Reports one field that differs from its expected value.
    task automatic check_field(input string name, input logic [15:0] exp_val,
                               input logic [15:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
            errors++;
        end
    endtask

    // Results are checked before the stream byte of the same edge is taken in,
    // since no byte can produce a result in its own cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fill        = 0;
            in_frame    = 1'b0;
            left        = '0;
            cur_profile = '0;
            cur_rate    = '0;
            cur_length  = '0;
            frame_no    = '0;
            owed_bytes.delete();
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                seen.frame_byte    = out_ch.frame_byte;
                seen.frame_first   = out_ch.frame_first;
                seen.frame_end     = out_ch.frame_end;
                seen.audio_profile = out_ch.audio_profile;
                seen.rate_index    = out_ch.rate_index;
                seen.frame_bytes   = out_ch.frame_bytes;
                seen.frame_index   = out_ch.frame_index;
                if (owed_bytes.size() == 0) begin
                    $display("%0t: frame byte mismatch: expected none, actual %h",
                             $time, seen);
                    errors++;
                end else begin
                    want = owed_bytes.pop_front();
                    check_field("frame_byte", 16'(want.frame_byte), 16'(seen.frame_byte));
                    check_field("frame_first", 16'(want.frame_first),
                                16'(seen.frame_first));
                    check_field("frame_end", 16'(want.frame_end), 16'(seen.frame_end));
                    check_field("audio_profile", 16'(want.audio_profile),
                                16'(seen.audio_profile));
                    check_field("rate_index", 16'(want.rate_index), 16'(seen.rate_index));
                    check_field("frame_bytes", 16'(want.frame_bytes),
                                16'(seen.frame_bytes));
                    check_field("frame_index", want.frame_index, seen.frame_index);
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                split_stream_byte(in_ch.stream_byte);
            end
        end
        o_pending <= owed_bytes.size();
        o_errors  <= errors;
    end

endmodule

[bench/adts_frame_splitter_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADTS frame splitter testbench
// Feeds the splitter with ADTS streams: a short directed part, then random
// well-formed frames mixed with short-length headers, broken sync words and
// noise, under three idle patterns and a long output stall. A checker beside
// the block predicts every result.
// ----------------------------------------------------------------------------
module adts_frame_splitter_top_tb;
    import afs_pkg::*;

    localparam int HOLD_CYCLES  = 100;
    localparam int QUIET_LIMIT  = 1000;
    localparam int PHASE_BYTES  = 50;
    localparam int TAIL_CYCLES  = 20;

    logic i_clk = 1'b0;
    logic i_rst_n;

    afs_in_if  in_ch ();
    afs_out_if out_ch ();

    int   errors;
    int   pending;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    int   hold_requests = 0;
    int   hold_served = 0;
    int   hold_left = 0;
    int   quiet_cycles = 0;
    int   frame_bytes_sent;
    int   phase;
    int   pick;

    adts_frame_splitter_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    adts_frame_splitter_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    // Clock with a 20 ns period.
    always #10 i_clk = ~i_clk;

    // Offers one stream byte, idling first at the current rate, and returns
    // at the edge where the transaction takes place.
    task automatic push_byte(input logic [7:0] b);
        bit taken;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.stream_byte <= b;
        do begin
            @(negedge i_clk);
            taken = in_ch.ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    // Sends an ADTS header carrying the given length, then the frame body
    // when the sync word is intact and the length covers the header.
    task automatic send_adts(input int frame_len, input bit sync_ok,
                             input logic [7:0] prof_rate);
        logic [12:0] len;
        logic [7:0]  hdr [0:6];
        int          k;
        len    = 13'(frame_len);
        hdr[0] = SYNC_BYTE;
        hdr[1] = sync_ok ? {SYNC_NIBBLE, 4'($urandom)}
                         : {4'($urandom_range(0, 14)), 4'($urandom)};
        hdr[2] = prof_rate;
        hdr[3] = {6'($urandom), len[12:11]};
        hdr[4] = len[10:3];
        hdr[5] = {len[2:0], 5'($urandom)};
        hdr[6] = 8'($urandom);
        for (k = 0; k < 7; k++) begin
            push_byte(hdr[k]);
        end
        if (sync_ok && frame_len >= 7) begin
            for (k = 7; k < frame_len; k++) begin
                push_byte(8'($urandom));
            end
            frame_bytes_sent += frame_len;
        end
    endtask

    // Drops the valid and waits until every expected frame byte has arrived.
    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("adts_frame_splitter_top_tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus and verdict.
    initial begin
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.stream_byte <= 8'h00;
        frame_bytes_sent   = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: header-only frame with all tag bits low, a one-byte body
        // with all tag bits high, a length below the header, then noise.
        send_adts(7, 1'b1, 8'h00);
        send_adts(8, 1'b1, 8'hFF);
        send_adts(6, 1'b1, 8'($urandom));
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h00);
        drain();

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct  = 29;
                    rx_idle_pct <= 73;
                end
                1: begin
                    tx_idle_pct  = 73;
                    rx_idle_pct <= 29;
                end
                default: begin
                    tx_idle_pct  = 0;
                    rx_idle_pct <= 0;
                end
            endcase

            // Long output stall while frames keep coming in.
            if (phase == 2) begin
                hold_requests <= hold_requests + 1;
                repeat (4) send_adts(20, 1'b1, 8'($urandom));
            end

            frame_bytes_sent = 0;
            while (frame_bytes_sent < PHASE_BYTES) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    send_adts($urandom_range(7, 24), 1'b1, 8'($urandom));
                end else if (pick < 80) begin
                    send_adts($urandom_range(0, 6), 1'b1, 8'($urandom));
                end else if (pick < 90) begin
                    send_adts($urandom_range(7, 24), 1'b0, 8'($urandom));
                end else begin
                    repeat ($urandom_range(1, 5)) push_byte(8'($urandom));
                end
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("adts_frame_splitter_top_tb passed");
        end else begin
            $display("adts_frame_splitter_top_tb failed");
        end
        $finish;
    end

endmodule
